// File: sv/srq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srq_pkg
// Types, codes and constants shared by the sonar range qualifier.
// ----------------------------------------------------------------------------
package srq_pkg;

  localparam int DIST_W   = 16;
  localparam int RANGE_W  = 15;
  localparam int PCT_W    = 7;
  localparam int TIME_W   = 32;
  localparam int ERRCNT_W = 3;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 15;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam int DEF_ERROR_LIMIT     = 5;
  localparam int DEF_ACCEPT_DELAY_MS = 700;

  localparam logic [RANGE_W-1:0] MIN_RANGE_RST  = 15'd25;
  localparam logic [RANGE_W-1:0] MAX_RANGE_RST  = 15'd200;
  localparam logic [PCT_W-1:0]   TILT_LIMIT_RST = 7'd18;
  localparam logic [RANGE_W-1:0] JUMP_LIMIT_RST = 15'd50;

  localparam logic [PCT_W-1:0]         FULL_PCT   = 7'd100;
  localparam logic signed [DIST_W-1:0] NO_DIST    = -16'sd1;
  localparam logic signed [DIST_W-1:0] NO_READING = 16'sd0;

  typedef enum logic [CFG_AW-1:0] {
    REG_MIN_RANGE  = 2'd0,
    REG_MAX_RANGE  = 2'd1,
    REG_TILT_LIMIT = 2'd2,
    REG_JUMP_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_FIRST  = 2'd1,
    ST_STEADY = 2'd2
  } contact_t;

  typedef enum logic [1:0] {
    BR_UNKNOWN = 2'd0,
    BR_LOWER   = 2'd1,
    BR_UPPER   = 2'd2
  } breach_t;

endpackage
`default_nettype wire

// File: sv/sonar_range_qualifier.sv
// A result passes the input register, then the state and output-valid registers.
// Throughput: one transaction per cycle unless out_tready stalls the output;
// the qualification logic between the input register and the state registers is a
// single pass of compares and adds. Reset: synchronous, active low; clears the
// pipeline, the state and restores the register defaults.
`default_nettype none
// ----------------------------------------------------------------------------
// sonar_range_qualifier
// Qualifies raw sonar distance readings against range, tilt and jump limits
// and tracks a contact status.
// ----------------------------------------------------------------------------
module sonar_range_qualifier
  import srq_pkg::*;
#(
  parameter int ERROR_LIMIT     = DEF_ERROR_LIMIT,
  parameter int ACCEPT_DELAY_MS = DEF_ACCEPT_DELAY_MS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // raw_distance[15:0], level_percent[22:16], now_ms[54:23], zero[55]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // filtered_distance[15:0], contact_status[17:16], breach_code[19:18], zero[23:20]
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [CFG_DW-1:0]      cfg_wdata
);

  localparam logic [ERRCNT_W-1:0] ERR_LIM = ERRCNT_W'(ERROR_LIMIT);
  localparam logic [TIME_W-1:0]   DELAY   = TIME_W'(ACCEPT_DELAY_MS);

  logic [RANGE_W-1:0] min_range_r, max_range_r, jump_limit_r;
  logic [PCT_W-1:0]   tilt_limit_r;

  logic                     s1_valid_r;
  logic signed [DIST_W-1:0] s1_raw_r;
  logic [PCT_W-1:0]         s1_level_r;
  logic [TIME_W-1:0]        s1_now_r;
  logic                     out_valid_r;

  logic signed [DIST_W-1:0] current_r, current_nxt;
  logic signed [DIST_W-1:0] last_good_r, last_good_nxt;
  logic [ERRCNT_W-1:0]      err_cnt_r, err_cnt_nxt;
  logic [TIME_W-1:0]        deadline_r, deadline_nxt;
  contact_t                 status_r, status_nxt;
  breach_t                  breach_r, breach_nxt;

  logic                     advance;
  logic                     update;
  logic [PCT_W-1:0]         level_clip;
  logic [PCT_W-1:0]         tilt;
  logic                     tilt_ok;
  logic signed [DIST_W-1:0] min_s, max_s;
  logic                     sane;
  logic signed [DIST_W-1:0] cand;
  logic signed [DIST_W:0]   diff;
  logic [DIST_W:0]          mag;
  logic signed [DIST_W-1:0] cur;

  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || advance;
  assign update     = s1_valid_r && advance && (s1_raw_r != NO_READING);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, breach_r, status_r, current_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_range_r  <= MIN_RANGE_RST;
      max_range_r  <= MAX_RANGE_RST;
      tilt_limit_r <= TILT_LIMIT_RST;
      jump_limit_r <= JUMP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MIN_RANGE:  min_range_r  <= cfg_wdata;
        REG_MAX_RANGE:  max_range_r  <= cfg_wdata;
        REG_TILT_LIMIT: tilt_limit_r <= cfg_wdata[PCT_W-1:0];
        REG_JUMP_LIMIT: jump_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_raw_r   <= $signed(in_tdata[15:0]);
      s1_level_r <= in_tdata[22:16];
      s1_now_r   <= in_tdata[54:23];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_comb begin
    level_clip = (s1_level_r > FULL_PCT) ? FULL_PCT : s1_level_r;
    tilt       = FULL_PCT - level_clip;
    tilt_ok    = tilt < tilt_limit_r;
    min_s      = $signed({1'b0, min_range_r});
    max_s      = $signed({1'b0, max_range_r});
    sane       = (s1_raw_r >= min_s) && (s1_raw_r <= max_s) && tilt_ok;

    last_good_nxt = last_good_r;
    err_cnt_nxt   = err_cnt_r;
    breach_nxt    = breach_r;
    deadline_nxt  = deadline_r;
    status_nxt    = status_r;

    if (sane) begin
      last_good_nxt = s1_raw_r;
      err_cnt_nxt   = '0;
      breach_nxt    = BR_UNKNOWN;
      cand          = s1_raw_r;
    end else begin
      err_cnt_nxt = (err_cnt_r < ERR_LIM) ? err_cnt_r + 1'b1 : ERR_LIM;
      if (tilt_ok && (s1_raw_r != NO_DIST)) begin
        if (s1_raw_r <= min_s) breach_nxt = BR_LOWER;
        if (s1_raw_r >= max_s) breach_nxt = BR_UPPER;
      end else begin
        breach_nxt = BR_UNKNOWN;
      end
      cand = (err_cnt_nxt != ERR_LIM) ? last_good_r : NO_DIST;
    end

    diff = {cand[DIST_W-1], cand} - {current_r[DIST_W-1], current_r};
    mag  = diff[DIST_W] ? (DIST_W+1)'(0) - diff : diff;
    cur  = cand;
    if ((current_r != NO_DIST) && (cand != NO_DIST) && (jump_limit_r != '0)
        && (mag > {2'b00, jump_limit_r})) begin
      cur = NO_DIST;
    end
    current_nxt = cur;

    if (cur[DIST_W-1]) begin
      last_good_nxt = NO_DIST;
      status_nxt    = ST_NONE;
    end else begin
      case (status_r)
        ST_NONE: begin
          status_nxt   = ST_FIRST;
          deadline_nxt = s1_now_r + DELAY;
        end
        ST_FIRST: begin
          if (s1_now_r >= deadline_r) status_nxt = ST_STEADY;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_r   <= NO_DIST;
      last_good_r <= NO_DIST;
      err_cnt_r   <= '0;
      deadline_r  <= '0;
      status_r    <= ST_NONE;
      breach_r    <= BR_UNKNOWN;
    end else if (update) begin
      current_r   <= current_nxt;
      last_good_r <= last_good_nxt;
      err_cnt_r   <= err_cnt_nxt;
      deadline_r  <= deadline_nxt;
      status_r    <= status_nxt;
      breach_r    <= breach_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    err_cnt_r <= ERR_LIM)
    else $error("error count exceeds its limit");

  a_contact_has_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r != ST_NONE) |-> (current_r != NO_DIST))
    else $error("contact reported without a distance");

  a_lost_clears_good: assert property (@(posedge clk) disable iff (!rst_n)
    (current_r == NO_DIST) |-> (last_good_r == NO_DIST))
    else $error("last good distance kept after losing the distance");

  a_steady_via_first: assert property (@(posedge clk) disable iff (!rst_n)
    (status_r == ST_STEADY && $past(status_r) != ST_STEADY) |->
      ($past(status_r) == ST_FIRST))
    else $error("steady contact reached without first contact");
`endif

endmodule
`default_nettype wire
